// ===== sv/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// shared types, sizes and helpers of the sstf disk request scheduler
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W      = 8;
    localparam int WIN_W       = (CNT_W > STEP_W) ? CNT_W : STEP_W;
    localparam int DIST_W      = 17;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 112;

    typedef enum logic [1:0] {
        ST_DISPATCHED = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_ENQUEUED   = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_SHIFT,
        S_SCAN2,
        S_DONE
    } t_state;

    localparam logic MODE_ENQUEUE  = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    localparam logic CFG_NSTEP_ENABLE = 1'b0;
    localparam logic CFG_MAX_STEPS    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] arm_cylinder;
        logic [15:0] req_cylinder;
        logic [15:0] req_phys_sector;
        logic [23:0] req_logical_sector;
        logic        req_kind;
        logic [15:0] req_client;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_cylinder;
        logic [15:0] out_phys_sector;
        logic [23:0] out_logical_sector;
        logic        out_kind;
        logic [15:0] out_client;
        logic        next_valid;
        logic [15:0] next_cylinder;
        logic [15:0] next_phys_sector;
    } t_result;

    typedef struct packed {
        logic [15:0] cylinder;
        logic [15:0] phys_sector;
        logic [23:0] logical_sector;
        logic        kind;
        logic [15:0] client;
    } t_entry;

    // zero step count acts as max_steps, zero max_steps acts as one
    function automatic logic [STEP_W-1:0] eff_window(input logic [STEP_W-1:0] s,
                                                     input logic [STEP_W-1:0] mx);
        logic [STEP_W-1:0] w;
        if (s != '0)       w = s;
        else if (mx != '0) w = mx;
        else               w = STEP_W'(1);
        return w;
    endfunction

endpackage

// ===== sv/sstf_front.sv =====
// ----------------------------------------------------------------------------
// sstf_front
// two-entry input queue that takes transactions and tags their operation
// ----------------------------------------------------------------------------
module sstf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sstf_pkg::t_item i_item,
    output logic           o_valid,
    output logic           o_dispatch,
    output sstf_pkg::t_item o_item,
    input  logic           i_pop
);

    sstf_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;

    assign o_ready    = (r_cnt != 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];
    assign o_dispatch = (r_mem[r_rp].mode == sstf_pkg::MODE_DISPATCH);
    assign push       = i_valid && o_ready;
    assign pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/sstf_engine.sv =====
// ----------------------------------------------------------------------------
// sstf_engine
// request store, nearest-cylinder scans and compaction of the queue
// ----------------------------------------------------------------------------
module sstf_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_nstep_enable,
    input  logic [7:0]          i_max_steps,
    input  logic                i_valid,
    input  logic                i_dispatch,
    input  sstf_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_done,
    output sstf_pkg::t_result   o_result,
    input  logic                i_ack
);

    localparam int IW = sstf_pkg::IDX_W;
    localparam int CW = sstf_pkg::CNT_W;
    localparam int WW = sstf_pkg::WIN_W;
    localparam int SW = sstf_pkg::STEP_W;

    sstf_pkg::t_entry  r_mem [sstf_pkg::QUEUE_DEPTH];
    sstf_pkg::t_entry  r_rdata;
    sstf_pkg::t_state  r_state;
    sstf_pkg::t_state  n_state;
    sstf_pkg::t_result r_res;
    sstf_pkg::t_result res_init;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_step;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_pidx;
    logic              r_pv;
    logic [CW-1:0]     r_lim;
    logic [WW-1:0]     r_win;
    logic [WW-1:0]     r_carry;
    logic [CW-1:0]     r_best;
    logic [sstf_pkg::DIST_W-1:0] r_bd;
    logic [sstf_pkg::DIST_W-1:0] seek_gap;
    logic              scan_end;
    logic              shift_end;
    logic              better;
    logic              full;
    logic              scanning;
    logic [WW-1:0]     win0;
    logic [WW-1:0]     cnt_w;
    logic [CW-1:0]     nc;
    logic [WW-1:0]     s_dec;
    logic [SW-1:0]     step_new;
    logic [WW-1:0]     pw;

    assign cnt_w     = WW'(r_count);
    assign full      = (r_count == CW'(sstf_pkg::QUEUE_DEPTH));
    assign scanning  = (r_state == sstf_pkg::S_SCAN1) || (r_state == sstf_pkg::S_SCAN2);
    assign win0      = i_nstep_enable ? WW'(sstf_pkg::eff_window(r_step, i_max_steps)) : cnt_w;
    assign seek_gap  = (r_rdata.cylinder > i_item.arm_cylinder)
                     ? sstf_pkg::DIST_W'(r_rdata.cylinder - i_item.arm_cylinder)
                     : sstf_pkg::DIST_W'(i_item.arm_cylinder - r_rdata.cylinder);
    assign better    = r_pv && (seek_gap < r_bd);
    assign scan_end  = (r_idx == r_lim) && !r_pv;
    assign shift_end = (r_idx == r_count) && !r_pv;
    assign nc        = r_count - CW'(1);
    assign s_dec     = r_win - WW'(1);
    assign step_new  = (s_dec == '0) ? i_max_steps : s_dec[SW-1:0];
    assign pw        = !i_nstep_enable ? WW'(nc)
                     : ((r_carry == '0 || nc == '0)
                        ? WW'(sstf_pkg::eff_window(step_new, i_max_steps)) : r_carry);

    // result skeleton taken when a transaction starts
    always_comb begin
        res_init = '0;
        if (!i_dispatch) begin
            res_init.status = full ? sstf_pkg::ST_FULL : sstf_pkg::ST_ENQUEUED;
        end else if (r_count == '0) begin
            res_init.status = sstf_pkg::ST_EMPTY;
        end else begin
            res_init.status = sstf_pkg::ST_DISPATCHED;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sstf_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_dispatch && r_count != '0) n_state = sstf_pkg::S_SCAN1;
                    else                              n_state = sstf_pkg::S_DONE;
                end
            end
            sstf_pkg::S_SCAN1: if (scan_end)  n_state = sstf_pkg::S_SHIFT;
            sstf_pkg::S_SHIFT: begin
                if (shift_end) n_state = (nc == '0) ? sstf_pkg::S_DONE : sstf_pkg::S_SCAN2;
            end
            sstf_pkg::S_SCAN2: if (scan_end)  n_state = sstf_pkg::S_DONE;
            sstf_pkg::S_DONE:  if (i_ack)     n_state = sstf_pkg::S_IDLE;
            default:           n_state = sstf_pkg::S_IDLE;
        endcase
    end

    // outputs: the transaction leaves the input queue once its result is taken
    always_comb begin
        o_pop  = 1'b0;
        o_done = 1'b0;
        unique case (r_state)
            sstf_pkg::S_DONE: begin
                o_done = 1'b1;
                o_pop  = i_ack;
            end
            default: ;
        endcase
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sstf_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx[IW-1:0]];
        if (r_state == sstf_pkg::S_IDLE && i_valid && !i_dispatch && !full) begin
            r_mem[r_count[IW-1:0]] <= '{cylinder:       i_item.req_cylinder,
                                        phys_sector:    i_item.req_phys_sector,
                                        logical_sector: i_item.req_logical_sector,
                                        kind:           i_item.req_kind,
                                        client:         i_item.req_client};
        end else if (r_state == sstf_pkg::S_SHIFT && r_pv) begin
            r_mem[IW'(r_pidx - CW'(1))] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= '0;
            r_pv    <= 1'b0;
        end else begin
            // read pipeline used by scans and the shift
            if (scanning && r_idx != r_lim) begin
                r_pv   <= 1'b1;
                r_pidx <= r_idx;
                r_idx  <= r_idx + CW'(1);
            end else if (r_state == sstf_pkg::S_SHIFT && r_idx != r_count) begin
                r_pv   <= 1'b1;
                r_pidx <= r_idx;
                r_idx  <= r_idx + CW'(1);
            end else begin
                r_pv <= 1'b0;
            end

            unique case (r_state)
                sstf_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_res  <= res_init;
                        r_idx  <= '0;
                        r_bd   <= '1;
                        r_best <= '0;
                        if (!i_dispatch) begin
                            if (!full) r_count <= r_count + CW'(1);
                        end else if (r_count != '0) begin
                            r_win        <= win0;
                            r_lim        <= (win0 < cnt_w) ? win0[CW-1:0] : r_count;
                            r_carry      <= (win0 < cnt_w) ? '0 : win0 - cnt_w;
                        end
                    end
                end
                sstf_pkg::S_SCAN1: begin
                    if (better) begin
                        r_bd                     <= seek_gap;
                        r_best                   <= r_pidx;
                        r_res.out_cylinder       <= r_rdata.cylinder;
                        r_res.out_phys_sector    <= r_rdata.phys_sector;
                        r_res.out_logical_sector <= r_rdata.logical_sector;
                        r_res.out_kind           <= r_rdata.kind;
                        r_res.out_client         <= r_rdata.client;
                    end
                    if (scan_end) r_idx <= r_best + CW'(1);
                end
                sstf_pkg::S_SHIFT: begin
                    if (shift_end) begin
                        r_count <= nc;
                        if (i_nstep_enable) r_step <= step_new;
                        r_lim   <= (pw < WW'(nc)) ? pw[CW-1:0] : nc;
                        r_idx   <= '0;
                        r_bd    <= '1;
                    end
                end
                sstf_pkg::S_SCAN2: begin
                    if (better) begin
                        r_bd                   <= seek_gap;
                        r_res.next_valid       <= 1'b1;
                        r_res.next_cylinder    <= r_rdata.cylinder;
                        r_res.next_phys_sector <= r_rdata.phys_sector;
                    end
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sstf_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_lim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sstf_pkg::S_SCAN1) |-> (r_lim <= r_count && r_lim != '0))
        else $error("scan window outside queue");

    a_shift_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sstf_pkg::S_SHIFT && shift_end) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dispatch did not remove one entry");

endmodule

// ===== sv/sstf_disk_request_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_unit
// shortest-seek-time-first disk request queue with optional n-step window
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one transaction per item: tuser is the mode (0 enqueue,
//   1 dispatch), tdata the arm cylinder and the request to enqueue.
//   m_axis returns exactly one result transaction per input transaction:
//   tuser is the status, tdata the dispatched request and the next pick.
//   the config port (i_cfg_we, i_cfg_addr, i_cfg_wdata) is for the user to
//   write only while idle; the block itself does not enforce it
// operation
//   enqueue and empty dispatch go straight to the result; a dispatch scans
//   the window for the nearest cylinder, shifts later entries down, then
//   scans the peek window unless the queue is left empty, one entry a cycle
// reset
//   synchronous active low; queue empty, step count zero, registers reset
// stalls
//   a two-entry input queue keeps taking transactions while a result waits
//   in the output register; the engine holds its result until it is taken
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // arm_cylinder, req_cylinder, req_phys_sector, req_logical_sector,
    // req_kind, req_client, zero fill
    input  logic [95:0]  s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_cylinder, out_phys_sector, out_logical_sector, out_kind, out_client,
    // next_valid, next_cylinder, next_phys_sector, zero fill
    output logic [111:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    logic              r_nstep_enable;
    logic [7:0]        r_max_steps;
    sstf_pkg::t_item   in_item;
    sstf_pkg::t_item   q_item;
    logic              q_valid;
    logic              q_dispatch;
    logic              pop;
    logic              done;
    logic              ack;
    sstf_pkg::t_result res;
    sstf_pkg::t_result r_out;
    logic              r_out_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nstep_enable <= 1'b0;
            r_max_steps    <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sstf_pkg::CFG_NSTEP_ENABLE: r_nstep_enable <= i_cfg_wdata[0];
                sstf_pkg::CFG_MAX_STEPS:    r_max_steps    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // unpack the input transaction
    assign in_item = '{mode:               s_axis_tuser,
                       arm_cylinder:       s_axis_tdata[15:0],
                       req_cylinder:       s_axis_tdata[31:16],
                       req_phys_sector:    s_axis_tdata[47:32],
                       req_logical_sector: s_axis_tdata[71:48],
                       req_kind:           s_axis_tdata[72],
                       req_client:         s_axis_tdata[88:73]};

    sstf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .o_valid    (q_valid),
        .o_dispatch (q_dispatch),
        .o_item     (q_item),
        .i_pop      (pop)
    );

    sstf_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nstep_enable (r_nstep_enable),
        .i_max_steps    (r_max_steps),
        .i_valid        (q_valid),
        .i_dispatch     (q_dispatch),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_done         (done),
        .o_result       (res),
        .i_ack          (ack)
    );

    // output register, loaded when empty or being drained
    assign ack = done && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (ack) r_out <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                  r_out_vld <= 1'b0;
        else if (ack)                  r_out_vld <= 1'b1;
        else if (m_axis_tready)        r_out_vld <= 1'b0;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {6'd0,
                            r_out.next_phys_sector,
                            r_out.next_cylinder,
                            r_out.next_valid,
                            r_out.out_client,
                            r_out.out_kind,
                            r_out.out_logical_sector,
                            r_out.out_phys_sector,
                            r_out.out_cylinder};

endmodule
